[sv/assert_macros.svh]
// Assertion helpers for the checker file slfd_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLFD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SLFD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

[sv/slfd_pkg.sv]
package slfd_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_PATTERN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_LENGTH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_LENGTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH_OFFSET = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD   = 3'd4;

  typedef struct packed {
    logic [31:0] sync_pattern;
    logic [2:0]  sync_length;
    logic [7:0]  header_length;
    logic [7:0]  length_offset;
    logic [23:0] max_payload;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    sync_pattern:  32'd0,
    sync_length:   3'd4,
    header_length: 8'd12,
    length_offset: 8'd4,
    max_payload:   24'd65536
  };

  // one output word
  typedef struct packed {
    logic       err;
    logic       last;
    logic       first;
    logic [7:0] data;
  } res_t;

endpackage

[sv/slfd_parse.sv]
module slfd_parse #(
  parameter int CAP   = 4,
  parameter int CNT_W = 3
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_take,
  input  logic [7:0]                 in_byte,
  input  slfd_pkg::cfg_t             cfg,
  output logic                       busy,
  output logic [CNT_W-1:0]           push_cnt,
  output slfd_pkg::res_t [CAP-1:0]   push_data
);

  localparam int WIN_B  = (CAP > 1) ? CAP - 1 : 1;
  localparam int FILL_W = (CAP > 1) ? $clog2(CAP) : 1;
  localparam int CW     = CNT_W + 1;

  typedef enum logic [1:0] {PH_HUNT, PH_HEAD, PH_PAY} phase_t;

  logic                in_vld_r;
  logic [7:0]          in_byte_r;
  phase_t              phase_r, phase_nxt;
  logic [7:0]          win_r [WIN_B];
  logic [7:0]          win_nxt [WIN_B];
  logic [FILL_W-1:0]   fill_r, fill_nxt;
  logic [7:0]          pos_r, pos_nxt;
  logic [31:0]         acc_r, acc_nxt;
  logic [23:0]         rem_r, rem_nxt;

  logic [CNT_W-1:0]         eff_len;
  logic [7:0]               seq [CAP];
  logic                     hit;
  slfd_pkg::res_t [CAP-1:0] hit_data;
  logic [31:0]              acc_hit;
  logic [7:0]               hdr_ofs;
  logic                     hdr_in_fld;
  logic                     end_hdr;

  assign busy = in_vld_r;

  // sync length clamped to 1..CAP
  always_comb begin
    if (cfg.sync_length == 3'd0) begin
      eff_len = CNT_W'(1);
    end else if (cfg.sync_length > 3'(CAP)) begin
      eff_len = CNT_W'(CAP);
    end else begin
      eff_len = CNT_W'(cfg.sync_length);
    end
  end

  // newest byte at index 0
  always_comb begin
    seq[0] = in_byte_r;
    for (int i = 1; i < CAP; i++) begin
      seq[i] = win_r[i-1];
    end
  end

  // match and burst words for each possible sync length, picked by eff_len
  always_comb begin
    hit      = 1'b0;
    hit_data = '0;
    for (int l = 1; l <= CAP; l++) begin
      if (eff_len == CNT_W'(l)) begin
        hit = (CW'(fill_r) + CW'(1)) >= CW'(eff_len);
        for (int k = 0; k < l; k++) begin
          if (seq[l-1-k] != cfg.sync_pattern[8*k +: 8]) begin
            hit = 1'b0;
          end
          hit_data[k].data = seq[l-1-k];
        end
      end
    end
    hit_data[0].first = 1'b1;
  end

  // length field bytes that fall inside the sync word
  always_comb begin
    acc_hit = '0;
    for (int k = 0; k < CAP; k++) begin
      for (int j = 0; j < 4; j++) begin
        if (CNT_W'(k) < eff_len && ({1'b0, cfg.length_offset} + 9'(j)) == 9'(k)) begin
          acc_hit[8*j +: 8] = acc_hit[8*j +: 8] | hit_data[k].data;
        end
      end
    end
  end

  assign hdr_ofs    = pos_r - cfg.length_offset;
  assign hdr_in_fld = (pos_r >= cfg.length_offset) && (hdr_ofs < 8'd4);

  always_comb begin
    phase_nxt = phase_r;
    win_nxt   = win_r;
    fill_nxt  = fill_r;
    pos_nxt   = pos_r;
    acc_nxt   = acc_r;
    rem_nxt   = rem_r;
    push_cnt  = '0;
    push_data = '0;
    end_hdr   = 1'b0;
    if (in_vld_r) begin
      unique case (phase_r)
        PH_HEAD: begin
          if (hdr_in_fld) begin
            acc_nxt = acc_r | (32'(in_byte_r) << {hdr_ofs[1:0], 3'b000});
          end
          pos_nxt           = pos_r + 8'd1;
          push_cnt          = CNT_W'(1);
          push_data[0].data = in_byte_r;
          end_hdr           = pos_nxt >= cfg.header_length;
        end
        PH_PAY: begin
          rem_nxt           = rem_r - 24'd1;
          push_cnt          = CNT_W'(1);
          push_data[0].data = in_byte_r;
          if (rem_nxt == 24'd0) begin
            push_data[0].last = 1'b1;
            phase_nxt         = PH_HUNT;
          end
        end
        default: begin
          if (!hit) begin
            win_nxt[0] = in_byte_r;
            for (int i = 1; i < WIN_B; i++) begin
              win_nxt[i] = win_r[i-1];
            end
            if (fill_r < FILL_W'(CAP - 1)) begin
              fill_nxt = fill_r + FILL_W'(1);
            end
            phase_nxt = PH_HUNT;
          end else begin
            for (int i = 0; i < WIN_B; i++) begin
              win_nxt[i] = 8'd0;
            end
            fill_nxt  = '0;
            acc_nxt   = acc_hit;
            push_cnt  = eff_len;
            push_data = hit_data;
            pos_nxt   = 8'(eff_len);
            phase_nxt = PH_HEAD;
            end_hdr   = 8'(eff_len) >= cfg.header_length;
          end
        end
      endcase

      // header done: on an oversize or zero length, flags go on the last word pushed this cycle
      if (end_hdr) begin
        if (acc_nxt > {8'd0, cfg.max_payload}) begin
          for (int p = 0; p < CAP; p++) begin
            if (CNT_W'(p) + CNT_W'(1) == push_cnt) begin
              push_data[p].last = 1'b1;
              push_data[p].err  = 1'b1;
            end
          end
          phase_nxt = PH_HUNT;
        end else if (acc_nxt == 32'd0) begin
          for (int p = 0; p < CAP; p++) begin
            if (CNT_W'(p) + CNT_W'(1) == push_cnt) begin
              push_data[p].last = 1'b1;
            end
          end
          phase_nxt = PH_HUNT;
        end else begin
          rem_nxt   = acc_nxt[23:0];
          phase_nxt = PH_PAY;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    in_byte_r <= in_byte;
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      phase_r  <= PH_HUNT;
      fill_r   <= '0;
      pos_r    <= '0;
      acc_r    <= '0;
      rem_r    <= '0;
      for (int i = 0; i < WIN_B; i++) begin
        win_r[i] <= 8'd0;
      end
    end else begin
      in_vld_r <= in_take;
      phase_r  <= phase_nxt;
      fill_r   <= fill_nxt;
      pos_r    <= pos_nxt;
      acc_r    <= acc_nxt;
      rem_r    <= rem_nxt;
      win_r    <= win_nxt;
    end
  end

endmodule

[sv/slfd_oq.sv]
module slfd_oq #(
  parameter int CAP   = 4,
  parameter int CNT_W = 3,
  parameter int DEPTH = 12,
  parameter int CQ_W  = 4
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [CNT_W-1:0]          push_cnt,
  input  slfd_pkg::res_t [CAP-1:0]  push_data,
  input  logic                      pop,
  output slfd_pkg::res_t            head,
  output logic [CQ_W-1:0]           count
);

  slfd_pkg::res_t  q_r [DEPTH];
  slfd_pkg::res_t  q_nxt [DEPTH];
  logic [CQ_W-1:0] count_r, count_nxt;
  logic [CQ_W-1:0] keep;

  assign head  = q_r[0];
  assign count = count_r;

  // shift down on pop, append pushed words behind the survivors
  always_comb begin
    keep = count_r - CQ_W'(pop);
    for (int j = 0; j < DEPTH; j++) begin
      q_nxt[j] = q_r[j];
      if (pop && j < DEPTH - 1) begin
        q_nxt[j] = q_r[(j + 1 < DEPTH) ? j + 1 : j];
      end
      for (int p = 0; p < CAP; p++) begin
        if (CNT_W'(p) < push_cnt && (keep + CQ_W'(p)) == CQ_W'(j)) begin
          q_nxt[j] = push_data[p];
        end
      end
    end
    count_nxt = keep + CQ_W'(push_cnt);
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

[sv/sync_length_frame_deframer.sv]
// Sync-word / length-field deframer. Takes one received byte per in_ word and
// hunts for the configured sync word (1..4 bytes, sliding exact match). On a
// match it emits the sync bytes, the rest of the header, and then as many
// payload bytes as the 4-byte little-endian length at length_offset says.
// out_tuser[0] marks the first sync byte of a frame, out_tlast the final byte,
// and out_tuser[1] a frame cut short because the length exceeded max_payload.
// Rate: one in_ word per clock, sustained, while the output keeps up. Output
// is one word per clock while out_tready is high; a sync hit turns one byte
// into up to sync-length words, so the output queue (3 x sync capacity words)
// absorbs them; in_tready drops unless a worst-case burst per byte held or
// offered fits. Bytes pass a parse and a queue register. The user writes
// configuration via cfg_ only while idle; the block does not enforce it.
module sync_length_frame_deframer #(
  parameter int SYNC_BYTES = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata: [7:0] rx_byte
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,
  // out_tdata: [7:0] frame_byte
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [7:0]                       out_tdata,
  output logic                             out_tlast,
  // out_tuser: [0] frame_first, [1] frame_error
  output logic [1:0]                       out_tuser,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [slfd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [slfd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // sync words longer than four bytes act as four
  localparam int CAP   = (SYNC_BYTES < 4) ? SYNC_BYTES : 4;
  localparam int CNT_W = $clog2(CAP + 1);
  localparam int DEPTH = 3 * CAP;
  localparam int CQ_W  = $clog2(DEPTH + 1);
  localparam int SUM_W = $clog2(DEPTH + 2 * CAP + 1);

  slfd_pkg::cfg_t           cfg_r, cfg_nxt;
  logic                     in_take;
  logic                     busy;
  logic [CNT_W-1:0]         push_cnt;
  slfd_pkg::res_t [CAP-1:0] push_data;
  slfd_pkg::res_t           head;
  logic [CQ_W-1:0]          count;
  logic                     pop;
  logic [SUM_W-1:0]         need;

  // register file; a write takes effect at once, so the host keeps writes
  // to idle periods
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        slfd_pkg::REG_SYNC_PATTERN:  cfg_nxt.sync_pattern  = cfg_data;
        slfd_pkg::REG_SYNC_LENGTH:   cfg_nxt.sync_length   = cfg_data[2:0];
        slfd_pkg::REG_HEADER_LENGTH: cfg_nxt.header_length = cfg_data[7:0];
        slfd_pkg::REG_LENGTH_OFFSET: cfg_nxt.length_offset = cfg_data[7:0];
        slfd_pkg::REG_MAX_PAYLOAD:   cfg_nxt.max_payload   = cfg_data[23:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= slfd_pkg::CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // room check: queued words, plus a worst-case burst from the byte in the
  // parse register, plus another for the byte being taken now
  assign need      = SUM_W'(count) + (busy ? SUM_W'(CAP) : '0) + SUM_W'(CAP);
  assign in_tready = need <= SUM_W'(DEPTH);
  assign in_take   = in_tvalid & in_tready;

  slfd_parse #(
    .CAP   (CAP),
    .CNT_W (CNT_W)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_take   (in_take),
    .in_byte   (in_tdata),
    .cfg       (cfg_r),
    .busy      (busy),
    .push_cnt  (push_cnt),
    .push_data (push_data)
  );

  slfd_oq #(
    .CAP   (CAP),
    .CNT_W (CNT_W),
    .DEPTH (DEPTH),
    .CQ_W  (CQ_W)
  ) u_oq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .count     (count)
  );

  assign out_tvalid = count != '0;
  assign pop        = out_tvalid & out_tready;
  assign out_tdata  = head.data;
  assign out_tlast  = head.last;
  assign out_tuser  = {head.err, head.first};

endmodule

[sv/slfd_chk.sv]
`include "assert_macros.svh"

module slfd_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast,
  input logic [1:0] out_tuser
);

  // a stalled word holds
  `SLFD_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser))

  // an error only ever closes a frame
  `SLFD_ASSERT_IMP(a_err_last, clk, rst_n, out_tvalid && out_tuser[1], out_tlast)

  // output cannot wake up without a byte taken earlier, through the parse and queue registers
  `SLFD_ASSERT_IMP(a_out_src, clk, rst_n, $rose(out_tvalid), $past(in_tvalid && in_tready, 2))

  // the queue only drains through a handshake
  `SLFD_ASSERT_IMP(a_out_drain, clk, rst_n, $fell(out_tvalid), $past(out_tready))

endmodule

bind sync_length_frame_deframer slfd_chk u_chk (.*);

[dv/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SYNC_BYTES   = 4;
  localparam int CYCLE_LIMIT  = 1000000;
  // settle time once the expected-word queue is empty: pipe latency plus margin
  localparam int DRAIN_CYCLES = 16;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2
  } parse_phase_e;

  // Deframer scoreboard: mirrors the parse state and registers, turns each
  // accepted rx byte into the frame words it should produce, and checks
  // output words against them in order.
  class deframe_scoreboard;
    slfd_pkg::cfg_t regs;
    logic [23:0]    window;
    logic [1:0]     fill;
    parse_phase_e   phase;
    logic [7:0]     hdr_pos;
    logic [31:0]    len_acc;
    logic [23:0]    remaining;
    slfd_pkg::res_t expected_words[$];
    int             mismatches;

    function new();
      regs       = slfd_pkg::CFG_RESET;
      window     = '0;
      fill       = '0;
      phase      = PH_HUNT;
      hdr_pos    = '0;
      len_acc    = '0;
      remaining  = '0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [slfd_pkg::CFG_IDX_W-1:0] idx, logic [31:0] d);
      case (idx)
        slfd_pkg::REG_SYNC_PATTERN:  regs.sync_pattern  = d;
        slfd_pkg::REG_SYNC_LENGTH:   regs.sync_length   = d[2:0];
        slfd_pkg::REG_HEADER_LENGTH: regs.header_length = d[7:0];
        slfd_pkg::REG_LENGTH_OFFSET: regs.length_offset = d[7:0];
        slfd_pkg::REG_MAX_PAYLOAD:   regs.max_payload   = d[23:0];
        default: ;
      endcase
    endfunction

    // sync length in use: 0 counts as 1, clipped to the window capacity
    function int sync_bytes_used();
      int n;
      int cap;
      n   = int'(regs.sync_length);
      cap = (SYNC_BYTES < 4) ? SYNC_BYTES : 4;
      if (cap < 1) cap = 1;
      if (n < 1) n = 1;
      if (n > cap) n = cap;
      return n;
    endfunction

    function void absorb_length(int pos, logic [7:0] b);
      int off;
      off = int'(regs.length_offset);
      if (pos >= off && pos - off < 4) len_acc |= 32'(b) << (8 * (pos - off));
    endfunction

    // header done: oversize aborts with error, zero closes, else payload
    function void close_header(inout slfd_pkg::res_t r);
      if (len_acc > 32'(regs.max_payload)) begin
        r.last = 1'b1;
        r.err  = 1'b1;
        phase  = PH_HUNT;
      end else if (len_acc == 32'd0) begin
        r.last = 1'b1;
        phase  = PH_HUNT;
      end else begin
        remaining = len_acc[23:0];
        phase     = PH_PAYLOAD;
      end
    endfunction

    function void note_rx_byte(logic [7:0] b);
      slfd_pkg::res_t r;
      int             n;
      logic [31:0]    seq;
      bit             hit;
      case (phase)
        PH_HEADER: begin
          absorb_length(int'(hdr_pos), b);
          hdr_pos = hdr_pos + 8'd1;
          r = '{err: 1'b0, last: 1'b0, first: 1'b0, data: b};
          if (hdr_pos >= regs.header_length) close_header(r);
          expected_words.push_back(r);
        end
        PH_PAYLOAD: begin
          remaining = remaining - 24'd1;
          r = '{err: 1'b0, last: (remaining == 24'd0), first: 1'b0, data: b};
          if (r.last) phase = PH_HUNT;
          expected_words.push_back(r);
        end
        default: begin
          n   = sync_bytes_used();
          seq = {window, b};
          hit = (int'(fill) + 1 >= n);
          for (int k = 0; k < n; k++)
            if (seq[8*(n-1-k) +: 8] != regs.sync_pattern[8*k +: 8]) hit = 1'b0;
          if (!hit) begin
            window = seq[23:0];
            if (fill < 2'd3) fill = fill + 2'd1;
            phase = PH_HUNT;
          end else begin
            // emit the held sync bytes plus this one; window restarts empty
            len_acc = '0;
            hdr_pos = 8'(n);
            phase   = PH_HEADER;
            for (int k = 0; k < n; k++) begin
              absorb_length(k, seq[8*(n-1-k) +: 8]);
              r = '{err: 1'b0, last: 1'b0, first: (k == 0), data: seq[8*(n-1-k) +: 8]};
              if (k == n - 1 && n >= int'(regs.header_length)) close_header(r);
              expected_words.push_back(r);
            end
            window = '0;
            fill   = '0;
          end
        end
      endcase
    endfunction

    function void check_frame_byte(logic [7:0] data, logic last, logic [1:0] user);
      slfd_pkg::res_t e;
      if (expected_words.size() == 0) begin
        $error("unexpected output word: frame_byte %02h", data);
        mismatches++;
        return;
      end
      e = expected_words.pop_front();
      if (data !== e.data) begin
        $error("frame_byte: expected %02h, got %02h", e.data, data);
        mismatches++;
      end
      if (user[0] !== e.first) begin
        $error("frame_first: expected %0b, got %0b", e.first, user[0]);
        mismatches++;
      end
      if (last !== e.last) begin
        $error("frame_last: expected %0b, got %0b", e.last, last);
        mismatches++;
      end
      if (user[1] !== e.err) begin
        $error("frame_error: expected %0b, got %0b", e.err, user[1]);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [7:0]                      in_tdata   = 8'd0;   // [7:0] rx_byte
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [7:0]                      out_tdata;           // [7:0] frame_byte
  logic                            out_tlast;
  logic [1:0]                      out_tuser;           // [0] frame_first, [1] frame_error
  logic                            cfg_valid  = 1'b0;
  logic                            cfg_ready;
  logic [slfd_pkg::CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [slfd_pkg::CFG_DATA_W-1:0] cfg_data   = '0;

  deframe_scoreboard sb;
  int                cycles     = 0;
  int                burst_left = 0;
  int                bytes_sent = 0;
  int                stall_cnt  = 0;
  int                stall_mode = 0;
  logic [7:0]        dir_bytes[$];

  sync_length_frame_deframer #(.SYNC_BYTES(SYNC_BYTES)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Output side: check each accepted word (pre-edge values), then pick the
  // next ready. Stall mode is re-picked at random at regular points of the
  // stall counter: always ready, random, periodic, mostly stalled.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_frame_byte(out_tdata, out_tlast, out_tuser);
    stall_cnt <= stall_cnt + 1;
    if (stall_cnt % 64 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(0, 3) != 0);
      2:       out_tready <= (stall_cnt % 8 < 3);
      default: out_tready <= ($urandom_range(0, 4) == 0);
    endcase
  end

  // One rx word. Sender runs in bursts; a gap is inserted before each new
  // burst (zero-length a quarter of the time). valid stays high within a burst.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_rx_byte(b);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic send_list();
    foreach (dir_bytes[i]) send_byte(dir_bytes[i]);
  endtask

  // Finish any open frame, then hold off until every expected word is out
  // and the pipe has had time to settle. Only after this are registers written.
  task automatic drain_to_idle();
    while (sb.phase != PH_HUNT) send_byte(8'($urandom));
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [31:0] pat, input logic [2:0] slen,
                           input logic [7:0] hlen, input logic [7:0] off,
                           input logic [23:0] mx);
    logic [slfd_pkg::CFG_IDX_W-1:0] idx [5];
    logic [31:0]                    vals[5];
    idx[0] = slfd_pkg::REG_SYNC_PATTERN;  vals[0] = pat;
    idx[1] = slfd_pkg::REG_SYNC_LENGTH;   vals[1] = 32'(slen);
    idx[2] = slfd_pkg::REG_HEADER_LENGTH; vals[2] = 32'(hlen);
    idx[3] = slfd_pkg::REG_LENGTH_OFFSET; vals[3] = 32'(off);
    idx[4] = slfd_pkg::REG_MAX_PAYLOAD;   vals[4] = 32'(mx);
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.set_reg(idx[i], vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // Hunting filler: never the first or last sync byte, so a match cannot
  // end on it and no stray frame with a random length gets started.
  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    logic [7:0] first_b;
    logic [7:0] last_b;
    int         n;
    n       = sb.sync_bytes_used();
    first_b = sb.regs.sync_pattern[7:0];
    last_b  = sb.regs.sync_pattern[8*(n-1) +: 8];
    do b = 8'($urandom); while (b == first_b || b == last_b);
    return b;
  endfunction

  // zero, oversize, exactly max, or a short legal length
  function automatic logic [31:0] pick_length();
    int          r;
    logic [31:0] mx;
    logic [31:0] v;
    r  = $urandom_range(0, 99);
    mx = 32'(sb.regs.max_payload);
    if (r < 15) return 32'd0;
    if (r < 35) begin
      v = $urandom;
      if (v <= mx) v = mx + 32'd1 + 32'($urandom_range(0, 3));
      return v;
    end
    if (r < 45 && mx <= 32'd40) return mx;
    if (mx == 32'd0) return 32'd0;
    return 32'($urandom_range(1, (mx < 32'd12) ? int'(mx) : 12));
  endfunction

  // Well-formed frame: sync, header with the length field at its offset,
  // random payload for as long as the block is in payload.
  task automatic send_frame();
    int          n;
    int          off;
    int          p;
    logic [31:0] len;
    n   = sb.sync_bytes_used();
    off = int'(sb.regs.length_offset);
    len = pick_length();
    for (p = 0; p < n; p++) send_byte(sb.regs.sync_pattern[8*p +: 8]);
    while (sb.phase == PH_HEADER) begin
      if (p >= off && p - off < 4) send_byte(len[8*(p-off) +: 8]);
      else send_byte(8'($urandom));
      p++;
    end
    while (sb.phase == PH_PAYLOAD) send_byte(8'($urandom));
  endtask

  // Random mix: mostly frames, some cut-off sync prefixes, some filler,
  // now and then a full pause until the output side has caught up.
  task automatic random_phase(input int target);
    int start;
    int r;
    int n;
    start = bytes_sent;
    while (bytes_sent - start < target) begin
      r = $urandom_range(0, 99);
      n = sb.sync_bytes_used();
      if (r < 65) begin
        send_frame();
      end else if (r < 80 && n > 1) begin
        for (int k = 0; k < $urandom_range(1, n - 1); k++)
          send_byte(sb.regs.sync_pattern[8*k +: 8]);
        send_byte(noise_byte());
      end else if (r < 95) begin
        repeat ($urandom_range(1, 4)) send_byte(noise_byte());
      end else begin
        drain_to_idle();
      end
    end
    drain_to_idle();
  endtask

  initial begin
    logic [2:0] slen;
    logic [7:0] off;
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // sliding match behind a repeated lead byte; length field overlaps the
    // sync word and comes out oversize against a zero max
    write_cfg(32'hBBAAAAAA, 3'd4, 8'd6, 8'd2, 24'd0);
    dir_bytes = {8'hAA, 8'hAA, 8'hAA, 8'hAA, 8'hBB, 8'h00, 8'h00};
    send_list();
    drain_to_idle();

    // sync length above range acts as four; header ends on the last sync
    // byte, so the length field is one sync byte plus missing zeros
    write_cfg(32'h0200FF00, 3'd7, 8'd4, 8'd3, 24'hFFFFFF);
    dir_bytes = {8'h00, 8'hFF, 8'h00, 8'h02, 8'hFF, 8'h00};
    send_list();
    drain_to_idle();

    // sync length zero acts as one; zero-length frame, then length == max
    write_cfg(32'hFFFFFFFF, 3'd0, 8'd5, 8'd1, 24'd1);
    dir_bytes = {8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00,
                 8'hFF, 8'h01, 8'h00, 8'h00, 8'h00, 8'h7E};
    send_list();
    drain_to_idle();

    // random part over several register settings
    write_cfg($urandom, 3'd4, 8'd12, 8'd4, 24'd2000);
    random_phase(20);
    write_cfg($urandom, 3'd1, 8'd5, 8'd1, 24'd0);
    random_phase(20);
    write_cfg($urandom, 3'd2, 8'd8, 8'd2, 24'hFFFFFF);
    random_phase(20);
    // length field runs past the header end
    write_cfg($urandom, 3'd3, 8'd6, 8'd4, 24'd40);
    random_phase(20);
    // length field starts inside the sync word
    write_cfg($urandom, 3'd4, 8'd10, 8'd1, 24'd300);
    random_phase(20);
    // long header, field at the last legal offset
    write_cfg(32'd0, 3'd4, 8'd32, 8'd28, 24'hFFFFFF);
    send_frame();
    drain_to_idle();
    repeat (2) begin
      slen = 3'($urandom_range(1, 4));
      off  = 8'($urandom_range(int'(slen), 16));
      write_cfg($urandom, slen, 8'(int'(off) + $urandom_range(4, 8)), off,
                24'($urandom_range(0, 60)));
      random_phase(20);
    end

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
